@@ rtl/core/transaction_id_table_defines.svh @@
// assertion macros for the transaction id table
// no dependencies; define ASSERT_OFF to drop all checks
`ifndef TRANSACTION_ID_TABLE_DEFINES_SVH
`define TRANSACTION_ID_TABLE_DEFINES_SVH

`ifndef ASSERT_OFF
`define TIDT_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("transaction_id_table check failed");
`define TIDT_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("transaction_id_table check failed");
`else
`define TIDT_ASSERT(label, clk, rst, prop)
`define TIDT_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

@@ rtl/core/tidt_pkg.sv @@
// types and codes shared by the transaction id table
// no dependencies
`default_nettype none

package tidt_pkg;

   localparam int unsigned ID_WIDTH      = 32;
   localparam int unsigned SERVICE_WIDTH = 8;

   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_LOOKUP = 2'd1,
      ACT_DELETE = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_NOT_FOUND = 2'd1,
      STAT_GEN_FAIL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic                     valid;
      logic [ID_WIDTH-1:0]      id;
      logic [ID_WIDTH-1:0]      orig;
      logic [SERVICE_WIDTH-1:0] service;
   } slot_entry_type;

endpackage

`default_nettype wire

@@ rtl/core/transaction_id_table.sv @@
// Transaction id table: ring of slots holding issued ids, original ids and service numbers.
// Depends on tidt_pkg and transaction_id_table_defines.svh.
// Lookup and delete scan the slots from slot 0 and answer when a valid slot holds the key,
// or after the last slot on a miss. Insert scans every slot for its candidate id and moves to
// the next candidate each time one is found held; the single slot memory read port reads one
// slot per cycle. One word at a time. An unused action code is answered without a scan.
// Reset: a clearing pass writes every slot invalid with busy high.
// The result is shown for one cycle on rsp_strobe and cannot be stalled.
`default_nettype none
`include "transaction_id_table_defines.svh"

module transaction_id_table #(
   parameter int TABLE_DEPTH = 256
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire tidt_pkg::action_type               req_action,
   input  wire logic [tidt_pkg::ID_WIDTH-1:0]      req_orig_id,
   input  wire logic [tidt_pkg::SERVICE_WIDTH-1:0] req_service_id,
   input  wire logic [tidt_pkg::ID_WIDTH-1:0]      req_key_id,
   output logic                                    rsp_strobe,
   output logic [tidt_pkg::ID_WIDTH-1:0]           rsp_assigned_id,
   output tidt_pkg::status_type                    rsp_status,
   output logic [tidt_pkg::ID_WIDTH-1:0]           rsp_stored_orig,
   output logic [tidt_pkg::SERVICE_WIDTH-1:0]      rsp_stored_service
);

   import tidt_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
      logic [AW-1:0] r;
      r = (a == LAST_SLOT) ? '0 : a + 1'b1;
      return r;
   endfunction

   state_type                state_ff, state_in;
   logic [AW-1:0]            addr_ff, addr_in;
   logic                     cmp_valid_ff, cmp_valid_in;
   logic [AW-1:0]            cmp_addr_ff, cmp_addr_in;
   logic [AW-1:0]            count_ff, count_in;
   logic [ID_WIDTH-1:0]      cand_ff, cand_in;
   logic [ID_WIDTH-1:0]      start_id_ff, start_id_in;
   logic [ID_WIDTH-1:0]      last_ff, last_in;
   logic [AW-1:0]            ptr_ff, ptr_in;
   action_type               op_ff, op_in;
   logic [ID_WIDTH-1:0]      orig_ff, orig_in;
   logic [SERVICE_WIDTH-1:0] service_ff, service_in;
   logic                     strobe_ff, strobe_in;
   logic [ID_WIDTH-1:0]      assigned_ff, assigned_in;
   status_type               status_ff, status_in;
   logic [ID_WIDTH-1:0]      sorig_ff, sorig_in;
   logic [SERVICE_WIDTH-1:0] sserv_ff, sserv_in;

   slot_entry_type           slot_mem [TABLE_DEPTH];
   slot_entry_type           rd_data_ff;
   logic                     mem_we;
   logic [AW-1:0]            mem_waddr;
   slot_entry_type           mem_wdata;

   logic                     is_ins;
   logic                     hit;
   logic                     last_cmp;
   logic [ID_WIDTH-1:0]      cand_next;
   logic                     ins_done;
   logic                     ins_fail;
   logic                     find_hit;
   logic                     find_miss;
   logic                     finish;
   logic                     accept;
   logic                     req_known;

   // compare stage
   always_comb begin
      is_ins    = (op_ff == ACT_INSERT);
      cand_next = cand_ff + 1'b1;
      last_cmp  = (count_ff == LAST_SLOT);
      hit       = cmp_valid_ff && rd_data_ff.valid && (rd_data_ff.id == cand_ff)
                  && !(is_ins && (cmp_addr_ff == ptr_ff));
      ins_done  = is_ins && cmp_valid_ff && !hit && last_cmp;
      ins_fail  = is_ins && hit && (cand_next == start_id_ff);
      find_hit  = !is_ins && hit;
      find_miss = !is_ins && cmp_valid_ff && !hit && last_cmp;
      finish    = (state_ff == ST_SCAN) && (ins_done || ins_fail || find_hit || find_miss);
      accept    = start && (state_ff == ST_IDLE);
      req_known = (req_action == ACT_INSERT) || (req_action == ACT_LOOKUP)
                  || (req_action == ACT_DELETE);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (addr_ff == LAST_SLOT) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept && req_known) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (finish) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and memory write port
   always_comb begin
      busy      = (state_ff != ST_IDLE);
      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      mem_wdata = '0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
         end
         ST_SCAN: begin
            if (ins_done || ins_fail) begin
               mem_we            = 1'b1;
               mem_waddr         = ptr_ff;
               mem_wdata.valid   = 1'b1;
               mem_wdata.id      = ins_fail ? '0 : cand_ff;
               mem_wdata.orig    = orig_ff;
               mem_wdata.service = service_ff;
            end else if (find_hit && op_ff == ACT_DELETE) begin
               mem_we    = 1'b1;
               mem_waddr = cmp_addr_ff;
            end
         end
         default: mem_we = 1'b0;
      endcase
   end

   // datapath next values
   always_comb begin
      addr_in      = addr_ff;
      cmp_valid_in = 1'b0;
      cmp_addr_in  = cmp_addr_ff;
      count_in     = count_ff;
      cand_in      = cand_ff;
      start_id_in  = start_id_ff;
      last_in      = last_ff;
      ptr_in       = ptr_ff;
      op_in        = op_ff;
      orig_in      = orig_ff;
      service_in   = service_ff;
      strobe_in    = 1'b0;
      assigned_in  = assigned_ff;
      status_in    = status_ff;
      sorig_in     = sorig_ff;
      sserv_in     = sserv_ff;
      case (state_ff)
         ST_CLEAR: begin
            addr_in = wrap_inc(addr_ff);
         end
         ST_IDLE: begin
            if (accept) begin
               op_in       = req_action;
               orig_in     = req_orig_id;
               service_in  = req_service_id;
               addr_in     = '0;
               count_in    = '0;
               start_id_in = last_ff + 1'b1;
               cand_in     = (req_action == ACT_INSERT) ? last_ff + 1'b1 : req_key_id;
               case (req_action)
                  ACT_INSERT, ACT_LOOKUP, ACT_DELETE: begin
                     strobe_in = 1'b0;
                  end
                  default: begin
                     // unused action code
                     strobe_in   = 1'b1;
                     assigned_in = '0;
                     status_in   = STAT_NOT_FOUND;
                     sorig_in    = '0;
                     sserv_in    = '0;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            addr_in      = wrap_inc(addr_ff);
            cmp_valid_in = !finish;
            cmp_addr_in  = addr_ff;
            if (cmp_valid_ff) begin
               if (hit && is_ins) begin
                  cand_in  = cand_next;
                  count_in = '0;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
            if (finish) begin
               strobe_in   = 1'b1;
               assigned_in = '0;
               status_in   = STAT_NOT_FOUND;
               sorig_in    = '0;
               sserv_in    = '0;
               if (ins_fail) begin
                  status_in = STAT_GEN_FAIL;
                  last_in   = '0;
                  ptr_in    = wrap_inc(ptr_ff);
               end else if (ins_done) begin
                  assigned_in = cand_ff;
                  status_in   = STAT_OK;
                  last_in     = cand_ff;
                  ptr_in      = wrap_inc(ptr_ff);
               end else if (find_hit) begin
                  status_in = STAT_OK;
                  if (op_ff == ACT_LOOKUP) begin
                     sorig_in = rd_data_ff.orig;
                     sserv_in = rd_data_ff.service;
                  end
               end
            end
         end
         default: cmp_valid_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         cmp_valid_ff <= 1'b0;
         count_ff     <= '0;
         last_ff      <= '0;
         ptr_ff       <= '0;
         strobe_ff    <= 1'b0;
         op_ff        <= ACT_INSERT;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         cmp_valid_ff <= cmp_valid_in;
         count_ff     <= count_in;
         last_ff      <= last_in;
         ptr_ff       <= ptr_in;
         strobe_ff    <= strobe_in;
         op_ff        <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_addr_ff <= cmp_addr_in;
      cand_ff     <= cand_in;
      start_id_ff <= start_id_in;
      orig_ff     <= orig_in;
      service_ff  <= service_in;
      assigned_ff <= assigned_in;
      status_ff   <= status_in;
      sorig_ff    <= sorig_in;
      sserv_ff    <= sserv_in;
   end

   // slot memory
   always_ff @(posedge clock) begin
      if (mem_we) slot_mem[mem_waddr] <= mem_wdata;
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= slot_mem[addr_ff];
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_assigned_id    = assigned_ff;
   assign rsp_status         = status_ff;
   assign rsp_stored_orig    = sorig_ff;
   assign rsp_stored_service = sserv_ff;

   `TIDT_ASSERT(a_start_scans, clock, reset, (accept && req_known) |=> (state_ff == ST_SCAN))
   `TIDT_ASSERT(a_idle_no_write, clock, reset, (state_ff == ST_IDLE) |-> !mem_we)
   `TIDT_ASSERT(a_fail_zero_id, clock, reset, strobe_ff && status_ff == STAT_GEN_FAIL |-> assigned_ff == '0)
   `TIDT_ASSERT(a_result_when_free, clock, reset, strobe_ff |-> !busy)
   `TIDT_ASSERT_ALWAYS(a_reset_clears, clock, $past(reset) |-> (state_ff == ST_CLEAR && !strobe_ff))

endmodule

`default_nettype wire

@@ tb/transaction_id_checker.sv @@
// checker for the transaction id table: watches request and result words, keeps its own
// copy of the ring table, predicts every answer and compares it field by field
// depends on tidt_pkg
module transaction_id_checker #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  tidt_pkg::action_type               req_action,
   input  logic [tidt_pkg::ID_WIDTH-1:0]      req_orig_id,
   input  logic [tidt_pkg::SERVICE_WIDTH-1:0] req_service_id,
   input  logic [tidt_pkg::ID_WIDTH-1:0]      req_key_id,
   input  logic                               rsp_strobe,
   input  logic [tidt_pkg::ID_WIDTH-1:0]      rsp_assigned_id,
   input  tidt_pkg::status_type               rsp_status,
   input  logic [tidt_pkg::ID_WIDTH-1:0]      rsp_stored_orig,
   input  logic [tidt_pkg::SERVICE_WIDTH-1:0] rsp_stored_service,
   output int                                 failures,
   output int                                 pending,
   output int                                 found_count
);
   import tidt_pkg::*;

   typedef struct packed {
      logic [ID_WIDTH-1:0]      assigned_id;
      status_type               status;
      logic [ID_WIDTH-1:0]      stored_orig;
      logic [SERVICE_WIDTH-1:0] stored_service;
   } id_answer_type;

   logic [ID_WIDTH-1:0]      last_issued;
   int unsigned              ring_ptr;
   logic                     slot_held    [TABLE_DEPTH];
   logic [ID_WIDTH-1:0]      slot_id      [TABLE_DEPTH];
   logic [ID_WIDTH-1:0]      slot_orig    [TABLE_DEPTH];
   logic [SERVICE_WIDTH-1:0] slot_service [TABLE_DEPTH];
   id_answer_type            due_answers [$];

   function automatic int held_slot(logic [ID_WIDTH-1:0] id);
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (slot_held[i] && slot_id[i] == id) begin
            return i;
         end
      end
      return -1;
   endfunction

   function automatic id_answer_type resolve_request(action_type act,
         logic [ID_WIDTH-1:0] orig, logic [SERVICE_WIDTH-1:0] service,
         logic [ID_WIDTH-1:0] key);
      id_answer_type       ans;
      logic [ID_WIDTH-1:0] from_id;
      logic [ID_WIDTH-1:0] cand;
      logic                failed;
      int                  p;
      int                  idx;
      ans = '{assigned_id: '0, status: STAT_NOT_FOUND, stored_orig: '0, stored_service: '0};
      case (act)
         ACT_INSERT: begin
            if (ring_ptr >= TABLE_DEPTH) begin
               ring_ptr = 0;
            end
            p = ring_ptr;
            slot_held[p] = 1'b0;
            from_id = last_issued + 1;
            cand = from_id;
            failed = 1'b0;
            while (held_slot(cand) >= 0) begin
               cand = cand + 1;
               if (cand == from_id) begin
                  failed = 1'b1;
                  cand = '0;
                  break;
               end
            end
            last_issued = cand;
            idx = held_slot(cand);
            if (idx >= 0) begin
               slot_held[idx] = 1'b0;
            end
            slot_held[p] = 1'b1;
            slot_id[p] = cand;
            slot_orig[p] = orig;
            slot_service[p] = service;
            ring_ptr = p + 1;
            if (ring_ptr >= TABLE_DEPTH) begin
               ring_ptr = 0;
            end
            ans.assigned_id = cand;
            ans.status = failed ? STAT_GEN_FAIL : STAT_OK;
         end
         ACT_LOOKUP: begin
            idx = held_slot(key);
            if (idx >= 0) begin
               ans.status = STAT_OK;
               ans.stored_orig = slot_orig[idx];
               ans.stored_service = slot_service[idx];
               found_count++;
            end
         end
         ACT_DELETE: begin
            idx = held_slot(key);
            if (idx >= 0) begin
               slot_held[idx] = 1'b0;
               ans.status = STAT_OK;
               found_count++;
            end
         end
         default: begin
         end
      endcase
      return ans;
   endfunction

   function automatic void check_field(string name, logic [ID_WIDTH-1:0] want,
         logic [ID_WIDTH-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      id_answer_type want;
      if (reset) begin
         last_issued = '0;
         ring_ptr = 0;
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            slot_held[i] = 1'b0;
         end
         due_answers.delete();
         failures = 0;
         found_count = 0;
         pending <= 0;
      end else begin
         if (rsp_strobe) begin
            if (due_answers.size() == 0) begin
               $error("result word with no answer expected");
               failures++;
            end else begin
               want = due_answers.pop_front();
               check_field("assigned_id", want.assigned_id, rsp_assigned_id);
               check_field("status", want.status, rsp_status);
               check_field("stored_orig", want.stored_orig, rsp_stored_orig);
               check_field("stored_service", want.stored_service, rsp_stored_service);
            end
         end
         if (start && !busy) begin
            due_answers.push_back(resolve_request(req_action, req_orig_id, req_service_id,
                                                  req_key_id));
         end
         pending <= due_answers.size();
      end
   end

endmodule

@@ tb/transaction_id_table_test.sv @@
// testbench top for the transaction id table: drives directed and random request words
// with random gaps, and gives the verdict from the checker's failure count
// depends on tidt_pkg, transaction_id_table and transaction_id_checker
module transaction_id_table_test;
   import tidt_pkg::*;

   localparam int TABLE_DEPTH  = 256;
   localparam int IDLE_LIMIT   = 4 * (TABLE_DEPTH + 2) * (TABLE_DEPTH + 1);
   localparam int RANDOM_WORDS = 740;
   localparam action_type ACT_UNUSED = action_type'(2'd3);

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   action_type               req_action = ACT_INSERT;
   logic [ID_WIDTH-1:0]      req_orig_id = '0;
   logic [SERVICE_WIDTH-1:0] req_service_id = '0;
   logic [ID_WIDTH-1:0]      req_key_id = '0;
   logic                     rsp_strobe;
   logic [ID_WIDTH-1:0]      rsp_assigned_id;
   status_type               rsp_status;
   logic [ID_WIDTH-1:0]      rsp_stored_orig;
   logic [SERVICE_WIDTH-1:0] rsp_stored_service;

   int failures;
   int pending;
   int found_count;
   int issued_total = 0;
   int sent_count [4] = '{default: 0};
   int idle_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   transaction_id_table #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_orig_id       (req_orig_id),
      .req_service_id    (req_service_id),
      .req_key_id        (req_key_id),
      .rsp_strobe        (rsp_strobe),
      .rsp_assigned_id   (rsp_assigned_id),
      .rsp_status        (rsp_status),
      .rsp_stored_orig   (rsp_stored_orig),
      .rsp_stored_service(rsp_stored_service)
   );

   transaction_id_checker #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) i_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_orig_id       (req_orig_id),
      .req_service_id    (req_service_id),
      .req_key_id        (req_key_id),
      .rsp_strobe        (rsp_strobe),
      .rsp_assigned_id   (rsp_assigned_id),
      .rsp_status        (rsp_status),
      .rsp_stored_orig   (rsp_stored_orig),
      .rsp_stored_service(rsp_stored_service),
      .failures          (failures),
      .pending           (pending),
      .found_count       (found_count)
   );

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", idle_cycles);
         $display("transaction_id_table_test NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_word(action_type act, logic [ID_WIDTH-1:0] orig,
         logic [SERVICE_WIDTH-1:0] service, logic [ID_WIDTH-1:0] key);
      start <= 1'b1;
      req_action <= act;
      req_orig_id <= orig;
      req_service_id <= service;
      req_key_id <= key;
      do @(posedge clock); while (busy);
      sent_count[act]++;
      if (act == ACT_INSERT) begin
         issued_total++;
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   initial begin
      int                  roll;
      int                  lo;
      bit                  calm;
      action_type          act;
      logic [ID_WIDTH-1:0] key;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty table, field extremes, hits, misses, delete then lookup, unused code
      send_word(ACT_LOOKUP, '0, '0, '0);
      send_word(ACT_DELETE, '1, '1, '0);
      send_word(ACT_INSERT, '0, '0, '1);
      send_word(ACT_INSERT, '1, '1, '0);
      send_word(ACT_INSERT, 32'hA5A5_A5A5, 8'h5A, 32'h5A5A_5A5A);
      send_word(ACT_LOOKUP, '1, '1, 32'd1);
      send_word(ACT_LOOKUP, '0, '0, 32'd2);
      send_word(ACT_LOOKUP, '0, '0, 32'd3);
      send_word(ACT_LOOKUP, '0, '0, '1);
      send_word(ACT_DELETE, '0, '0, 32'd2);
      send_word(ACT_LOOKUP, '0, '0, 32'd2);
      send_word(ACT_DELETE, '0, '0, 32'd2);
      send_word(ACT_UNUSED, '1, '1, 32'd1);
      send_word(ACT_UNUSED, '0, '0, 32'd3);
      send_word(ACT_LOOKUP, '0, '0, 32'd3);
      send_word(ACT_INSERT, 32'h5A5A_5A5A, 8'hA5, '0);
      send_word(ACT_DELETE, '0, '0, 32'd1);
      send_word(ACT_LOOKUP, '0, '0, 32'd4);
      wait_drained();

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         calm = (n >= 250 && n < 400);
         if (n == 500) begin
            wait_drained();
         end else if (!calm && $urandom_range(0, 99) < 11) begin
            start <= 1'b0;
            if ($urandom_range(0, 2) == 0) begin
               repeat ($urandom_range(1, TABLE_DEPTH + 40)) @(posedge clock);
            end else begin
               repeat ($urandom_range(1, 8)) @(posedge clock);
            end
         end
         roll = $urandom_range(0, 99);
         act = roll < 45 ? ACT_INSERT : roll < 75 ? ACT_LOOKUP :
               roll < 97 ? ACT_DELETE : ACT_UNUSED;
         // keys mostly aim at ids still in the ring
         lo = issued_total > TABLE_DEPTH - 1 ? issued_total - (TABLE_DEPTH - 1) : 1;
         roll = $urandom_range(0, 99);
         if (roll < 60 && issued_total > 0) begin
            key = $urandom_range(issued_total, lo);
         end else if (roll < 68) begin
            key = issued_total + $urandom_range(1, 3);
         end else if (roll < 75) begin
            key = lo - $urandom_range(1, 20);
         end else if (roll < 90) begin
            key = $urandom;
         end else begin
            key = (roll % 2 == 0) ? '1 : '0;
         end
         send_word(act, $urandom, $urandom_range(0, 255), key);
      end

      wait_drained();
      repeat (TABLE_DEPTH + 4) @(posedge clock);
      $display("covered %0d inserts, %0d lookups, %0d deletes and %0d unused-code words",
               sent_count[ACT_INSERT], sent_count[ACT_LOOKUP], sent_count[ACT_DELETE],
               sent_count[ACT_UNUSED]);
      $display("%0d lookups or deletes found their id; the ring went round %0d times",
               found_count, sent_count[ACT_INSERT] / TABLE_DEPTH);
      if (failures == 0) begin
         $display("transaction_id_table_test OK");
      end else begin
         $display("transaction_id_table_test NOT OK");
      end
      $finish;
   end

endmodule
